// ----- hw/rtl/hpid_pkg.sv -----
// hpid_pkg: shared types, widths, constants and the arctangent table
// for the heading pid controller; no dependencies
`timescale 1ns / 1ps

package hpid_pkg;

    // field widths
    localparam int GOAL_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int OUT_W     = 24;
    localparam int CFG_IDX_W = 2;

    // internal widths
    localparam int CORD_W    = 34;   // cordic x / y, inputs scaled by 2^14 plus growth
    localparam int Z_W       = 35;   // cordic angle, q30 radians
    localparam int EV_W      = 18;   // heading error before wrap
    localparam int ERR_W     = 16;   // heading error, q3.12
    localparam int DIFF_W    = 17;
    localparam int DERIV_W   = 20;
    localparam int INTEG_W   = 32;   // integral, q15.16
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = GAIN_W + MUL_B_W;
    localparam int ACC_W     = 50;
    localparam int ATAN_W    = 31;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_LEN  = 24;

    localparam int PRESCALE_SH = 14;
    localparam int ERR_SH      = 18;
    localparam int ROUND_SH    = 12;

    typedef logic signed [CORD_W-1:0]  t_cord;
    typedef logic signed [Z_W-1:0]     t_z;
    typedef logic signed [EV_W-1:0]    t_ev;
    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [DERIV_W-1:0] t_deriv;
    typedef logic signed [INTEG_W-1:0] t_integ;
    typedef logic signed [INTEG_W:0]   t_integ_sum;
    typedef logic signed [GAIN_W-1:0]  t_gain;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [OUT_W-1:0]   t_out;
    typedef logic signed [ATAN_W-1:0]  t_atan;
    typedef logic [ATAN_IDX_W-1:0]     t_atan_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP     = 2'd0,
        REG_GAIN_INTEGRAL = 2'd1,
        REG_GAIN_DERIV    = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORD,
        S_ERR,
        S_DERIV,
        S_INTEG,
        S_ACC_P,
        S_ACC_I,
        S_ACC_D,
        S_OUT
    } t_state;

    localparam t_gain GAIN_PROP_RST     = -16'sd1536;
    localparam t_gain GAIN_INTEGRAL_RST = 16'sd0;
    localparam t_gain GAIN_DERIV_RST    = 16'sd0;

    localparam t_z    PI_Q30     = 35'sd3373259426;
    localparam t_z    ERR_ROUND  = 35'sd131072;
    localparam t_ev   PI_Q12     = 18'sd12868;
    localparam t_ev   TWO_PI_Q12 = 18'sd25736;
    localparam t_gain TENTH_Q16  = 16'sd6554;
    localparam t_prod STEP_ROUND = t_prod'(2048);
    localparam t_acc  OUT_ROUND  = t_acc'(2048);
    localparam t_acc  OUT_MAX    = t_acc'(8388607);
    localparam t_acc  OUT_MIN    = -t_acc'(8388608);
    localparam t_integ_sum INTEG_MAX = t_integ_sum'(2147483647);
    localparam t_integ_sum INTEG_MIN = -t_integ_sum'(33'sd2147483648);

    // arctangent of 2^-i in q30, truncated toward zero
    function automatic t_atan atan_entry(input t_atan_idx idx);
        t_atan v;
        case (idx)
            5'd0:    v = 31'sh3243F6A8;
            5'd1:    v = 31'sh1DAC6705;
            5'd2:    v = 31'sh0FADBAFC;
            5'd3:    v = 31'sh07F56EA6;
            5'd4:    v = 31'sh03FEAB76;
            5'd5:    v = 31'sh01FFD55B;
            5'd6:    v = 31'sh00FFFAAA;
            5'd7:    v = 31'sh007FFF55;
            5'd8:    v = 31'sh003FFFEA;
            5'd9:    v = 31'sh001FFFFD;
            5'd10:   v = 31'sh000FFFFF;
            5'd11:   v = 31'sh0007FFFF;
            5'd12:   v = 31'sh0003FFFF;
            5'd13:   v = 31'sh0001FFFF;
            5'd14:   v = 31'sh0000FFFF;
            5'd15:   v = 31'sh00007FFF;
            5'd16:   v = 31'sh00003FFF;
            5'd17:   v = 31'sh00001FFF;
            5'd18:   v = 31'sh00000FFF;
            5'd19:   v = 31'sh000007FF;
            5'd20:   v = 31'sh000003FF;
            5'd21:   v = 31'sh000001FF;
            5'd22:   v = 31'sh000000FF;
            5'd23:   v = 31'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/heading_pid_controller_top.sv -----
// heading_pid_controller_top: turn-rate pid controller on the heading error
// to a goal point; uses hpid_pkg
`timescale 1ns / 1ps

// usage
// - input channel (i_in_valid / o_in_stall) carries a goal point i_goal_x,
//   i_goal_y in the robot frame; a transfer happens when valid is high and
//   stall is low
// - output channel (o_out_valid / i_out_stall) carries o_turn_rate (q11.12 rad/s)
//   and o_rate_clipped; one result per input item
// - config channel (i_cfg_valid / o_cfg_ready) writes the three q8.8 gains by
//   index; ready is always high; writes must come only while the block is
//   idle, which the block itself does not enforce; an index beyond the gain list is dropped
// - an item passes through the cordic iterations (one per cycle) and the
//   passes of the single multiplier; a new item is taken only once the
//   block has returned to idle
// - o_in_stall is high while an item is in flight; the output register
//   decouples the sides, so an item can enter while a result still waits
// - if the receiver stalls, the finished result waits in the last state
//   until the output register is free
// - reset (synchronous, active low) restores the default gains, clears the
//   prior error and the integral, and empties the output register

module heading_pid_controller_top
    import hpid_pkg::*;
#(
    parameter int CORDIC_STEPS = 14     // 8 .. 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [GOAL_W-1:0]    i_goal_x,
    input  logic signed [GOAL_W-1:0]    i_goal_y,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [OUT_W-1:0]     o_turn_rate,
    output logic                        o_rate_clipped,
    // config channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [GAIN_W-1:0]           i_cfg_data
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    // control state
    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    t_gain              r_gain_prop, r_gain_integral, r_gain_deriv;
    t_err               r_prior;
    t_integ             r_integ;

    // datapath registers
    t_cord              r_cx, r_cy;
    t_z                 r_z;
    logic               r_origin;
    t_err               r_err;
    t_deriv             r_deriv;
    t_prod              r_prod;
    t_acc               r_acc;
    t_out               r_turn_rate;
    logic               r_clipped;

    // decoded controls
    logic               in_xfer, out_xfer, cfg_xfer, out_free, out_load;
    t_gain              mul_a;
    t_mul_b             mul_b;
    t_prod              mul_p;

    // input pre-rotation
    t_cord              pre_x, pre_y;
    t_z                 pre_z;

    // cordic step
    t_cord              cord_dx, cord_dy;
    t_z                 cord_atan;

    // error, derivative, integral, output
    t_z                 err_z;
    t_ev                err_raw, err_wrap;
    t_diff              err_diff;
    t_prod              step_full;
    t_integ_sum         integ_sum;
    t_acc               out_full;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_turn_rate    = r_turn_rate;
    assign o_rate_clipped = r_clipped;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_CORD;
            S_CORD:  if (r_step == STEP_LAST) n_state = S_ERR;
            S_ERR:   n_state = S_DERIV;
            S_DERIV: n_state = S_INTEG;
            S_INTEG: n_state = S_ACC_P;
            S_ACC_P: n_state = S_ACC_I;
            S_ACC_I: n_state = S_ACC_D;
            S_ACC_D: n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: stall, output load and multiplier operand select
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        out_load   = 1'b0;
        mul_a      = TENTH_Q16;
        mul_b      = t_mul_b'(r_err);
        case (r_state)
            S_DERIV: begin
                mul_a = TENTH_Q16;
                mul_b = t_mul_b'(r_err);
            end
            S_INTEG: begin
                mul_a = r_gain_prop;
                mul_b = t_mul_b'(r_err);
            end
            S_ACC_P: begin
                mul_a = r_gain_integral;
                mul_b = t_mul_b'(r_integ);
            end
            S_ACC_I: begin
                mul_a = r_gain_deriv;
                mul_b = t_mul_b'(r_deriv);
            end
            S_OUT: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // the one shared multiplier
    assign mul_p = t_prod'(mul_a) * t_prod'(mul_b);

    // scale by 2^14 and fold the left half plane onto the right
    always_comb begin
        pre_x = t_cord'(i_goal_x) <<< PRESCALE_SH;
        pre_y = t_cord'(i_goal_y) <<< PRESCALE_SH;
        pre_z = '0;
        if (i_goal_x[GOAL_W-1]) begin
            pre_z = i_goal_y[GOAL_W-1] ? -PI_Q30 : PI_Q30;
            pre_x = -pre_x;
            pre_y = -pre_y;
        end
    end

    // one vectoring iteration per cycle
    assign cord_dx   = r_cy >>> r_step;
    assign cord_dy   = r_cx >>> r_step;
    assign cord_atan = t_z'(atan_entry(t_atan_idx'(r_step)));

    // negate, round to q3.12, wrap into +-pi
    always_comb begin
        err_z   = ERR_ROUND - r_z;
        err_raw = t_ev'(err_z >>> ERR_SH);
        if (err_raw < -PI_Q12) begin
            err_wrap = err_raw + TWO_PI_Q12;
        end else if (err_raw > PI_Q12) begin
            err_wrap = err_raw - TWO_PI_Q12;
        end else begin
            err_wrap = err_raw;
        end
    end

    assign err_diff = t_diff'(r_err) - t_diff'(r_prior);

    // integral step from e*6554, rounded to q16, then saturating add
    always_comb begin
        step_full = (r_prod + STEP_ROUND) >>> ROUND_SH;
        integ_sum = t_integ_sum'(r_integ) + t_integ_sum'(step_full);
    end

    assign out_full = (r_acc + OUT_ROUND) >>> ROUND_SH;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_step          <= '0;
            r_out_valid     <= 1'b0;
            r_gain_prop     <= GAIN_PROP_RST;
            r_gain_integral <= GAIN_INTEGRAL_RST;
            r_gain_deriv    <= GAIN_DERIV_RST;
            r_prior         <= '0;
            r_integ         <= '0;
        end else begin
            r_state <= n_state;

            if (in_xfer) begin
                r_step <= '0;
            end else if (r_state == S_CORD) begin
                r_step <= r_step + 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_xfer) begin
                case (i_cfg_index)
                    REG_GAIN_PROP:     r_gain_prop     <= t_gain'(i_cfg_data);
                    REG_GAIN_INTEGRAL: r_gain_integral <= t_gain'(i_cfg_data);
                    REG_GAIN_DERIV:    r_gain_deriv    <= t_gain'(i_cfg_data);
                    default: begin
                    end
                endcase
            end

            if (r_state == S_DERIV) begin
                r_prior <= r_err;
            end

            if (r_state == S_INTEG) begin
                if (integ_sum > INTEG_MAX) begin
                    r_integ <= t_integ'(INTEG_MAX);
                end else if (integ_sum < INTEG_MIN) begin
                    r_integ <= t_integ'(INTEG_MIN);
                end else begin
                    r_integ <= t_integ'(integ_sum);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_cx     <= pre_x;
                    r_cy     <= pre_y;
                    r_z      <= pre_z;
                    r_origin <= (i_goal_x == '0) && (i_goal_y == '0);
                end
            end
            S_CORD: begin
                if (!r_cy[CORD_W-1]) begin
                    r_cx <= r_cx + cord_dx;
                    r_cy <= r_cy - cord_dy;
                    r_z  <= r_z + cord_atan;
                end else begin
                    r_cx <= r_cx - cord_dx;
                    r_cy <= r_cy + cord_dy;
                    r_z  <= r_z - cord_atan;
                end
            end
            S_ERR: begin
                r_err <= r_origin ? '0 : t_err'(err_wrap);
            end
            S_DERIV: begin
                // 10 * (e - prior e) as 8x + 2x
                r_deriv <= (t_deriv'(err_diff) <<< 3) + (t_deriv'(err_diff) <<< 1);
                r_prod  <= mul_p;
            end
            S_INTEG: begin
                r_acc  <= '0;
                r_prod <= mul_p;
            end
            S_ACC_P: begin
                r_acc  <= r_acc + (t_acc'(r_prod) <<< 4);
                r_prod <= mul_p;
            end
            S_ACC_I: begin
                r_acc  <= r_acc + t_acc'(r_prod);
                r_prod <= mul_p;
            end
            S_ACC_D: begin
                r_acc <= r_acc + (t_acc'(r_prod) <<< 4);
            end
            S_OUT: begin
                if (out_load) begin
                    if (out_full > OUT_MAX) begin
                        r_turn_rate <= t_out'(OUT_MAX);
                        r_clipped   <= 1'b1;
                    end else if (out_full < OUT_MIN) begin
                        r_turn_rate <= t_out'(OUT_MIN);
                        r_clipped   <= 1'b1;
                    end else begin
                        r_turn_rate <= t_out'(out_full);
                        r_clipped   <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
